// ----- design/twl_pkg.sv -----
package twl_pkg;

  // Node memory geometry
  localparam int NODE_COUNT = 32768;
  localparam int NODE_AW    = $clog2(NODE_COUNT);
  // Link counter must be able to hold NODE_COUNT itself
  localparam int LINK_W     = NODE_AW + 1;

  // Input kind codes (carried on s_tuser)
  localparam logic KIND_NODE = 1'b0;
  localparam logic KIND_CHAR = 1'b1;

  // Read address select codes
  localparam logic [1:0] ADDR_CUR   = 2'd0;
  localparam logic [1:0] ADDR_CHILD = 2'd1;
  localparam logic [1:0] ADDR_SIB   = 2'd2;

  // One trie node as stored in memory
  typedef struct packed {
    logic [7:0]         symbol;
    logic [15:0]        code;
    logic [NODE_AW-1:0] child;
    logic [NODE_AW-1:0] sibling;
  } node_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       start_word;
    logic       latch_char;
    logic       take_t;
    logic       t_from_child;
    logic       t_from_sib;
    logic       links_clr;
    logic       links_inc;
    logic [1:0] addr_sel;
    logic       out_load;
    logic       out_fail;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic child_zero;
    logic sib_zero;
    logic sym_match;
    logic links_at_max;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/twl_datapath.sv -----
module twl_datapath import twl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [NODE_AW-1:0] cfg_wdata,
  input  logic               wr_en,
  input  logic [NODE_AW-1:0] wr_addr,
  input  node_t              wr_node,
  input  logic [7:0]         char_sym,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata
);

  node_t              mem [NODE_COUNT];
  node_t              rd_node;
  logic [NODE_AW-1:0] rd_addr;
  logic [NODE_AW-1:0] root;
  logic [NODE_AW-1:0] cur;
  logic [NODE_AW-1:0] t_node;
  logic [7:0]         sym;
  logic [LINK_W-1:0]  links;
  logic               found;
  logic [15:0]        entry_index;

  // Root register
  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (cfg_we) begin
      root <= cfg_wdata;
    end
  end

  // Read address select
  always_comb begin
    case (cmd.addr_sel)
      ADDR_CHILD: rd_addr = rd_node.child;
      ADDR_SIB:   rd_addr = rd_node.sibling;
      default:    rd_addr = cur;
    endcase
  end

  // Node memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_node;
    end
    rd_node <= mem[rd_addr];
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (cmd.start_word) begin
      cur <= root;
    end else if (cmd.take_t) begin
      cur <= t_node;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_char) begin
      sym <= char_sym;
    end
    if (cmd.t_from_child) begin
      t_node <= rd_node.child;
    end else if (cmd.t_from_sib) begin
      t_node <= rd_node.sibling;
    end
    if (cmd.links_clr) begin
      links <= '0;
    end else if (cmd.links_inc) begin
      links <= links + LINK_W'(1);
    end
  end

  // Status back to the controller
  assign status.child_zero   = (rd_node.child == '0);
  assign status.sib_zero     = (rd_node.sibling == '0);
  assign status.sym_match    = (rd_node.symbol == sym);
  assign status.links_at_max = (links == LINK_W'(NODE_COUNT));
  assign status.out_free     = !m_tvalid || m_tready;

  // Result from the final node code
  assign found       = !cmd.out_fail && (rd_node.code != 16'd0);
  assign entry_index = found ? (rd_node.code - 16'd1) : 16'd0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {7'd0, entry_index, found};
    end
  end

endmodule

// ----- design/twl_ctrl.sv -----
module twl_ctrl import twl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_kind,
  input  logic       in_last,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHILD_REQ = 3'd1;
  localparam logic [2:0] S_CHILD_CHK = 3'd2;
  localparam logic [2:0] S_SIB_CHK   = 3'd3;
  localparam logic [2:0] S_END       = 3'd4;
  localparam logic [2:0] S_RESULT    = 3'd5;

  logic [2:0] state, state_next;
  logic       mid_word, mid_word_next;
  logic       failed, failed_next;
  logic       last_r, last_r_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mid_word <= 1'b0;
      failed   <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state    <= state_next;
      mid_word <= mid_word_next;
      failed   <= failed_next;
      last_r   <= last_r_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    mid_word_next = mid_word;
    failed_next   = failed;
    last_r_next   = last_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.addr_sel  = ADDR_CUR;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_kind == KIND_CHAR) begin
          cmd.latch_char = 1'b1;
          last_r_next    = in_last;
          if (!mid_word) begin
            // new word: restart from the root
            cmd.start_word = 1'b1;
            mid_word_next  = 1'b1;
            failed_next    = 1'b0;
            state_next     = S_CHILD_REQ;
          end else if (failed) begin
            state_next = S_END;
          end else begin
            state_next = S_CHILD_REQ;
          end
        end
      end
      S_CHILD_REQ: begin
        state_next = S_CHILD_CHK;
      end
      S_CHILD_CHK: begin
        if (status.child_zero) begin
          failed_next = 1'b1;
          state_next  = S_END;
        end else begin
          cmd.t_from_child = 1'b1;
          cmd.links_clr    = 1'b1;
          cmd.addr_sel     = ADDR_CHILD;
          state_next       = S_SIB_CHK;
        end
      end
      S_SIB_CHK: begin
        if (status.sym_match) begin
          cmd.take_t = 1'b1;
          state_next = S_END;
        end else if (status.sib_zero || status.links_at_max) begin
          failed_next = 1'b1;
          state_next  = S_END;
        end else begin
          cmd.t_from_sib = 1'b1;
          cmd.links_inc  = 1'b1;
          cmd.addr_sel   = ADDR_SIB;
        end
      end
      S_END: begin
        // read the current node for its code
        state_next = last_r ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_fail  = failed;
          mid_word_next = 1'b0;
          failed_next   = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/trie_word_lookup.sv -----
// Trie word lookup over a first-child / next-sibling node memory.
// Input stream (s_*): s_tuser selects the kind. A node write (kind 0) stores
// one node at node_addr; a character (kind 1) advances the word walk, and
// s_tlast marks the last character of a word.
// Output stream (m_*): one transaction per last character, giving found and
// entry_index (entry code minus one, zero when not found).
// cfg_we / cfg_wdata set root_node; write it only while the block is idle.
// Steps: a node write is stored while idle. A character passes a child
// request, a child check, one sibling check per node on the sibling chain
// (at least one) and an end step that reads the node code; a failed or
// already failed word skips steps, and a last character adds a result step.
// Node memory reads are registered, so the chain length sets the rate.
// One item is in work at a time; s_tready is high only between items.
// The result register holds a finished result while the next item is taken;
// a stalled receiver only blocks once a further result is ready.
// Reset clears the walk state, root_node and the output valid; the node
// memory is not cleared and must be loaded before lookups.
module trie_word_lookup import twl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // node_addr[14:0], node_symbol[22:15], node_code[38:23],
  // node_child[53:39], node_sibling[68:54], sym[76:69], zero pad [79:77]
  input  logic [79:0]  s_tdata,
  // kind[0]
  input  logic [0:0]   s_tuser,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found[0], entry_index[16:1], zero pad [23:17]
  output logic [23:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;
  node_t      wr_node;
  logic       wr_en;

  // Unpack a node write
  assign wr_node.symbol  = s_tdata[22:15];
  assign wr_node.code    = s_tdata[38:23];
  assign wr_node.child   = s_tdata[53:39];
  assign wr_node.sibling = s_tdata[68:54];
  assign wr_en = s_tvalid && s_tready && (s_tuser[0] == KIND_NODE);

  twl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser[0]),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  twl_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr_en     (wr_en),
    .wr_addr   (s_tdata[14:0]),
    .wr_node   (wr_node),
    .char_sym  (s_tdata[76:69]),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- design/twl_checker.sv -----
module twl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Not found always reports a zero index
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
    else $error("nonzero index on a miss");

  // A found word never wraps the code to all ones
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[16:1] != 16'hFFFF)
    else $error("entry index out of range");

  // No result appears right after an input transaction
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result too soon after input");

  // Reset empties the output
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind trie_word_lookup twl_checker u_twl_checker (.*);
